### src/sps_pkg.sv
// Shared constants, codes and control types of the sensor poll scheduler.
`default_nettype none

package sps_pkg;

    // Default number of sensor channels; channels 0 and 1 are the fast ones.
    localparam int unsigned NUM_CHANNELS_DEF = 12;
    localparam int unsigned FIRST_SLOW       = 2;

    // Configuration port geometry.
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd10;
    localparam logic [7:0]  ERROR_LIMIT_RST = 8'd20;
    localparam logic [15:0] STUCK_LIMIT_RST = 16'd1500;

    // Saturation value of the failure counts and the error run.
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Operation codes.
    localparam logic [1:0] OP_POLL        = 2'd0;
    localparam logic [1:0] OP_RESTART     = 2'd1;
    localparam logic [1:0] OP_RESUME_SCAN = 2'd2;
    localparam logic [1:0] OP_RESUME_ODO  = 2'd3;

    // Poll outcome codes; any other code counts as an error response.
    localparam logic [1:0] OUTC_OK      = 2'd0;
    localparam logic [1:0] OUTC_PENDING = 2'd2;

    // Action codes.
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_STORE       = 3'd1;
    localparam logic [2:0] ACT_CLEAR_FIELD = 3'd2;
    localparam logic [2:0] ACT_RECONNECT   = 3'd3;
    localparam logic [2:0] ACT_CLEAR_CODES = 3'd4;
    localparam logic [2:0] ACT_SCAN_CODES  = 3'd5;
    localparam logic [2:0] ACT_READ_ODO    = 3'd6;

    // Schedule phases.
    localparam logic [1:0] PH_FAST0 = 2'd0;
    localparam logic [1:0] PH_FAST1 = 2'd1;
    localparam logic [1:0] PH_SLOW  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVAL,
        ST_SEARCH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic latch_item;
        logic check;
        logic eval;
        logic search;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic check_final;
        logic need_search;
        logic search_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### src/sps_ctrl.sv
// Sequencing state machine of the sensor poll scheduler.
`default_nettype none

module sps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sps_pkg::t_dp_status i_status,
    output sps_pkg::t_dp_cmd    o_cmd
);
    import sps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.check_final ? ST_OUT : ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_search ? ST_SEARCH : ST_OUT;
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_status.search_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/sps_dp.sv
// Datapath of the sensor poll scheduler: channel state, counters, timer and result register.
`default_nettype none

module sps_dp #(
    parameter int unsigned NUM_CHANNELS = sps_pkg::NUM_CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sps_pkg::t_dp_cmd                 i_cmd,
    output sps_pkg::t_dp_status              o_status,
    input  logic [1:0]                       i_operation,
    input  logic [1:0]                       i_outcome,
    input  logic [31:0]                      i_now_ms,
    input  logic                             i_link_up,
    input  logic                             i_clear_request,
    input  logic                             i_scan_request,
    input  logic                             i_odometer_request,
    input  logic                             i_cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [2:0]                       o_action,
    output logic [3:0]                       o_action_channel,
    output logic [3:0]                       o_next_channel
);
    import sps_pkg::*;

    localparam int unsigned CW = $clog2(NUM_CHANNELS);
    localparam logic [CW-1:0] LastCh    = CW'(NUM_CHANNELS - 1);
    localparam logic [CW-1:0] FirstSlow = CW'(FIRST_SLOW);
    localparam logic [CW-1:0] SrchLast  = CW'(NUM_CHANNELS - 3);

    // Configuration.
    logic [7:0]  r_fail_limit,  n_fail_limit;
    logic [7:0]  r_error_limit, n_error_limit;
    logic [15:0] r_stuck_limit, n_stuck_limit;

    // Latched request.
    logic [1:0]  r_op,      n_op;
    logic [1:0]  r_outcome, n_outcome;
    logic [31:0] r_now,     n_now;
    logic        r_link,    n_link;
    logic        r_clr,     n_clr;
    logic        r_scan,    n_scan;
    logic        r_odo,     n_odo;

    // Schedule state.
    logic [1:0]    r_phase,  n_phase;
    logic [CW-1:0] r_cur,    n_cur;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [7:0]    r_err,    n_err;
    logic [31:0]   r_slot,   n_slot;
    logic [7:0]    r_fail [NUM_CHANNELS];
    logic [7:0]    n_fail [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_skip, n_skip;
    logic [NUM_CHANNELS-1:0] r_seen, n_seen;

    // Work registers of one request.
    logic          r_expired, n_expired;
    logic [2:0]    r_act,     n_act;
    logic [CW-1:0] r_ach,     n_ach;
    logic [CW-1:0] r_cnt,     n_cnt;

    // Result register.
    logic       r_out_valid, n_out_valid;
    logic [2:0] r_o_action,  n_o_action;
    logic [3:0] r_o_ach,     n_o_ach;
    logic [3:0] r_o_next,    n_o_next;

    logic [CW-1:0]   cand;
    logic [CW-1:0]   rd_addr;
    logic            skip_rd;
    logic [7:0]      fail_cur;
    logic [7:0]      fail_inc;
    logic [7:0]      err_inc;
    logic            limit_hit;
    logic            err_hit;
    logic            seen_cur;
    logic            is_fail;
    logic            reconnect;
    logic            go;
    logic [31:0]     slot_eff;
    logic [31:0]     elapsed;
    logic            expired;
    logic [CW+3:0]   ach_ext;
    logic [CW+3:0]   cur_ext;

    // Next slow channel after the cursor, wrapping back to the first slow channel.
    assign cand    = (r_cursor == LastCh) ? FirstSlow : r_cursor + CW'(1);
    assign rd_addr = i_cmd.search ? cand : r_cur;
    assign skip_rd = r_skip[rd_addr];

    assign fail_cur  = r_fail[r_cur];
    assign fail_inc  = (fail_cur == COUNT_MAX) ? fail_cur : fail_cur + 8'd1;
    assign err_inc   = (r_err == COUNT_MAX) ? r_err : r_err + 8'd1;
    assign limit_hit = fail_inc >= r_fail_limit;
    assign err_hit   = err_inc >= r_error_limit;
    assign seen_cur  = r_seen[r_cur];

    assign is_fail   = (r_outcome != OUTC_OK) && ((r_outcome != OUTC_PENDING) || r_expired);
    assign reconnect = !skip_rd && is_fail && ((limit_hit && seen_cur) || err_hit);
    assign go        = skip_rd || (r_outcome == OUTC_OK) || (is_fail && !reconnect);

    // The first fast slot restarts the timer, so it sees no elapsed time.
    assign slot_eff = (r_phase == PH_FAST0) ? r_now : r_slot;
    assign elapsed  = r_now - slot_eff;
    assign expired  = elapsed > {16'h0000, r_stuck_limit};

    assign ach_ext = {4'b0000, r_ach};
    assign cur_ext = {4'b0000, r_cur};

    assign o_status.check_final = (r_op != OP_POLL) ||
                                  ((r_phase == PH_FAST0) &&
                                   (!r_link || r_clr || r_scan || r_odo));
    assign o_status.need_search = go && (r_phase == PH_FAST1);
    assign o_status.search_done = !skip_rd || (r_cnt == SrchLast);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_fail_limit  = r_fail_limit;
        n_error_limit = r_error_limit;
        n_stuck_limit = r_stuck_limit;
        n_op          = r_op;
        n_outcome     = r_outcome;
        n_now         = r_now;
        n_link        = r_link;
        n_clr         = r_clr;
        n_scan        = r_scan;
        n_odo         = r_odo;
        n_phase       = r_phase;
        n_cur         = r_cur;
        n_cursor      = r_cursor;
        n_err         = r_err;
        n_slot        = r_slot;
        n_fail        = r_fail;
        n_skip        = r_skip;
        n_seen        = r_seen;
        n_expired     = r_expired;
        n_act         = r_act;
        n_ach         = r_ach;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid;
        n_o_action    = r_o_action;
        n_o_ach       = r_o_ach;
        n_o_next      = r_o_next;

        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FAIL_LIMIT:  n_fail_limit  = i_cfg_data[7:0];
                CFG_ERROR_LIMIT: n_error_limit = i_cfg_data[7:0];
                CFG_STUCK_LIMIT: n_stuck_limit = i_cfg_data[15:0];
                default: begin
                end
            endcase
        end

        if (i_cmd.latch_item) begin
            n_op      = i_operation;
            n_outcome = i_outcome;
            n_now     = i_now_ms;
            n_link    = i_link_up;
            n_clr     = i_clear_request;
            n_scan    = i_scan_request;
            n_odo     = i_odometer_request;
        end

        if (i_cmd.check) begin
            n_act = ACT_NONE;
            n_ach = '0;
            unique case (r_op)
                OP_RESTART: begin
                    n_phase  = PH_FAST0;
                    n_cur    = '0;
                    n_cursor = CW'(1);
                    n_err    = '0;
                    n_slot   = '0;
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        n_fail[i] = '0;
                    end
                    n_skip = '0;
                    n_seen = '0;
                end
                OP_RESUME_SCAN, OP_RESUME_ODO: begin
                    n_phase = PH_FAST0;
                    n_cur   = '0;
                    if (r_op == OP_RESUME_ODO) begin
                        n_err = '0;
                    end
                end
                OP_POLL: begin
                    n_expired = expired;
                    if (r_phase == PH_FAST0) begin
                        priority if (!r_link) begin
                            n_act = ACT_RECONNECT;
                        end else if (r_clr) begin
                            n_act = ACT_CLEAR_CODES;
                        end else if (r_scan) begin
                            n_act = ACT_SCAN_CODES;
                        end else if (r_odo) begin
                            n_act = ACT_READ_ODO;
                        end else begin
                            n_cur  = '0;
                            n_slot = r_now;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.eval) begin
            n_ach = r_cur;
            n_act = ACT_NONE;
            if (!skip_rd) begin
                if (r_outcome == OUTC_OK) begin
                    n_fail[r_cur] = '0;
                    n_seen[r_cur] = 1'b1;
                    n_err         = '0;
                    n_act         = ACT_STORE;
                end else if (is_fail) begin
                    n_fail[r_cur] = fail_inc;
                    if (!(limit_hit && seen_cur)) begin
                        if (limit_hit) begin
                            n_skip[r_cur] = 1'b1;
                            n_act         = ACT_CLEAR_FIELD;
                        end
                        n_err = err_inc;
                    end
                    if (reconnect) begin
                        n_act = ACT_RECONNECT;
                    end
                end
            end
            if (go) begin
                priority case (r_phase)
                    PH_FAST0: begin
                        n_phase = PH_FAST1;
                        n_cur   = CW'(1);
                        n_slot  = r_now;
                    end
                    PH_FAST1: begin
                        n_cnt = '0;
                    end
                    default: begin
                        n_phase = PH_FAST0;
                    end
                endcase
            end
        end

        if (i_cmd.search) begin
            n_cursor = cand;
            n_cnt    = r_cnt + CW'(1);
            if (!skip_rd) begin
                n_phase = PH_SLOW;
                n_cur   = cand;
                n_slot  = r_now;
            end else if (r_cnt == SrchLast) begin
                n_phase = PH_FAST0;
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_o_action  = r_act;
            n_o_ach     = ach_ext[3:0];
            n_o_next    = (r_phase == PH_FAST0) ? 4'd0 : cur_ext[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit  <= FAIL_LIMIT_RST;
            r_error_limit <= ERROR_LIMIT_RST;
            r_stuck_limit <= STUCK_LIMIT_RST;
            r_phase       <= PH_FAST0;
            r_cur         <= '0;
            r_cursor      <= CW'(1);
            r_err         <= '0;
            r_slot        <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_fail[i] <= '0;
            end
            r_skip        <= '0;
            r_seen        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_fail_limit  <= n_fail_limit;
            r_error_limit <= n_error_limit;
            r_stuck_limit <= n_stuck_limit;
            r_phase       <= n_phase;
            r_cur         <= n_cur;
            r_cursor      <= n_cursor;
            r_err         <= n_err;
            r_slot        <= n_slot;
            r_fail        <= n_fail;
            r_skip        <= n_skip;
            r_seen        <= n_seen;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_outcome  <= n_outcome;
        r_now      <= n_now;
        r_link     <= n_link;
        r_clr      <= n_clr;
        r_scan     <= n_scan;
        r_odo      <= n_odo;
        r_expired  <= n_expired;
        r_act      <= n_act;
        r_ach      <= n_ach;
        r_cnt      <= n_cnt;
        r_o_action <= n_o_action;
        r_o_ach    <= n_o_ach;
        r_o_next   <= n_o_next;
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_o_action;
    assign o_action_channel = r_o_ach;
    assign o_next_channel   = r_o_next;

endmodule

`default_nettype wire

### src/sensor_poll_scheduler_unit.sv
// Top level of the sensor poll scheduler: controller and datapath.
//
//  Channel | Signals                                        | Direction
//  --------+------------------------------------------------+----------
//  in      | i_in_valid / o_in_stall, operation .. odometer | to block
//  out     | o_out_valid / i_out_stall, action, channels    | from block
//  cfg     | i_cfg_wr_en, i_cfg_index, i_cfg_data           | to block
//
// A poll request passes through capture, check (operation, link, service
// requests and the stuck-poll timer), evaluation of the outcome and loading of
// the result register; one that the check settles alone (restart, resume, or
// in the first fast slot a dropped link or service request) skips evaluation.
// After the second fast channel the search tests slow candidates in turn, up to
// NUM_CHANNELS - 2 of them, until it finds one that is not skipped.
// Reset is synchronous and active low; it restores the configuration defaults
// and clears all per-channel state at once. The result register parts the two
// sides: a new request is taken while an earlier result still waits, and a
// stalled result only holds back the next request at its final step.
`default_nettype none

module sensor_poll_scheduler_unit #(
    parameter int unsigned NUM_CHANNELS = sps_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_operation,
    input  logic [1:0]                     i_outcome,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_link_up,
    input  logic                           i_clear_request,
    input  logic                           i_scan_request,
    input  logic                           i_odometer_request,
    input  logic                           i_cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_action,
    output logic [3:0]                     o_action_channel,
    output logic [3:0]                     o_next_channel
);
    import sps_pkg::*;

    // Commands from the controller and status back from the datapath.
    t_dp_cmd    cmd;
    t_dp_status status;

    sps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the schedule, the per-channel counters and flags,
    // the configuration and the result register.
    sps_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_operation        (i_operation),
        .i_outcome          (i_outcome),
        .i_now_ms           (i_now_ms),
        .i_link_up          (i_link_up),
        .i_clear_request    (i_clear_request),
        .i_scan_request     (i_scan_request),
        .i_odometer_request (i_odometer_request),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_action           (o_action),
        .o_action_channel   (o_action_channel),
        .o_next_channel     (o_next_channel)
    );

endmodule

`default_nettype wire

### src/sps_checker.sv
// Port-level checker of the sensor poll scheduler and its bind to the top level.
`default_nettype none

module sps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_action,
    input logic [3:0] o_action_channel,
    input logic [3:0] o_next_channel
);
    import sps_pkg::*;

    // No result is offered straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_action) && $stable(o_action_channel) &&
            $stable(o_next_channel))
        else $error("stalled result changed");

    // One request at a time: the cycle after a request is taken, input stalls.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is at work");

    // Service actions are reported with channel 0 and the schedule stays at its start.
    a_service_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action == ACT_CLEAR_CODES || o_action == ACT_SCAN_CODES ||
                        o_action == ACT_READ_ODO) |->
            o_action_channel == 4'd0 && o_next_channel == 4'd0)
        else $error("service action with a channel");

    // Action code seven is never produced.
    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_action != 3'd7)
        else $error("undefined action code");

endmodule

bind sensor_poll_scheduler_unit sps_checker u_sps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_action         (o_action),
    .o_action_channel (o_action_channel),
    .o_next_channel   (o_next_channel)
);

`default_nettype wire

### tb/sensor_poll_scheduler_unit_tb.sv
// Self-checking testbench of the sensor poll scheduler with its own schedule predictor.
`default_nettype none

module sensor_poll_scheduler_unit_tb;

    import sps_pkg::*;

    localparam int unsigned NCH            = NUM_CHANNELS_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Longest walk of the slow channel search plus some margin.
    localparam int unsigned SETTLE_CYCLES  = NCH + 8;

    // Outcome codes that the package leaves unnamed; both count as an error response.
    localparam logic [1:0] OUTC_ERROR = 2'd1;
    localparam logic [1:0] OUTC_ODD   = 2'd3;

    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  outcome;
        logic [31:0] now_ms;
        logic        link_up;
        logic        clear_request;
        logic        scan_request;
        logic        odometer_request;
    } t_poll_req;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] action_channel;
        logic [3:0] next_channel;
    } t_sched_res;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HOLD
    } t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n            = 1'b0;
    logic                  i_in_valid         = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_operation;
    logic [1:0]            i_outcome;
    logic [31:0]           i_now_ms;
    logic                  i_link_up;
    logic                  i_clear_request;
    logic                  i_scan_request;
    logic                  i_odometer_request;
    logic                  i_cfg_wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data         = '0;
    logic                  o_out_valid;
    logic                  i_out_stall        = 1'b0;
    logic [2:0]            o_action;
    logic [3:0]            o_action_channel;
    logic [3:0]            o_next_channel;

    // Request currently presented to the block.
    t_poll_req drv_req = '0;

    assign i_operation        = drv_req.operation;
    assign i_outcome          = drv_req.outcome;
    assign i_now_ms           = drv_req.now_ms;
    assign i_link_up          = drv_req.link_up;
    assign i_clear_request    = drv_req.clear_request;
    assign i_scan_request     = drv_req.scan_request;
    assign i_odometer_request = drv_req.odometer_request;

    sensor_poll_scheduler_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_outcome          (i_outcome),
        .i_now_ms           (i_now_ms),
        .i_link_up          (i_link_up),
        .i_clear_request    (i_clear_request),
        .i_scan_request     (i_scan_request),
        .i_odometer_request (i_odometer_request),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_action           (o_action),
        .o_action_channel   (o_action_channel),
        .o_next_channel     (o_next_channel)
    );

    // Predicted scheduler state and limits.
    logic [7:0]  lim_fail  = FAIL_LIMIT_RST;
    logic [7:0]  lim_err   = ERROR_LIMIT_RST;
    logic [15:0] lim_stuck = STUCK_LIMIT_RST;
    logic [1:0]  sched_phase;
    logic [3:0]  sched_chan;
    logic [3:0]  slow_ptr;
    logic [7:0]  err_run;
    logic [31:0] slot_ms;
    logic [7:0]  fail_cnt [NCH];
    logic        skip_ch  [NCH];
    logic        seen_ok  [NCH];

    t_poll_req  pend_q[$];
    t_sched_res sched_expect_q[$];

    int unsigned reqs_issued     = 0;
    int unsigned results_checked = 0;
    int unsigned fail_count      = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned n_settings      = 1;
    int unsigned n_stores        = 0;
    int unsigned n_skips         = 0;
    int unsigned n_reconnects    = 0;
    int unsigned n_service       = 0;
    logic [31:0] clock_ms;

    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int unsigned stall_span = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_schedule();
        sched_phase = PH_FAST0;
        sched_chan  = 4'd0;
        slow_ptr    = 4'd1;
        err_run     = 8'd0;
        slot_ms     = 32'd0;
        for (int c = 0; c < NCH; c++) begin
            fail_cnt[c] = 8'd0;
            skip_ch[c]  = 1'b0;
            seen_ok[c]  = 1'b0;
        end
    endtask

    // Works out the result of one accepted request and updates the predicted state.
    task automatic predict_schedule(input t_poll_req r);
        t_sched_res res;
        logic [3:0] ch;
        logic [2:0] act;
        logic       go_on;
        logic       recon;
        logic       found;
        res   = '0;
        act   = ACT_NONE;
        recon = 1'b0;
        if (r.operation == OP_RESTART) begin
            clear_schedule();
        end else if (r.operation == OP_RESUME_SCAN || r.operation == OP_RESUME_ODO) begin
            if (r.operation == OP_RESUME_ODO)
                err_run = 8'd0;
            sched_phase = PH_FAST0;
            sched_chan  = 4'd0;
        end else if (sched_phase == PH_FAST0 && !r.link_up) begin
            res.action = ACT_RECONNECT;
        end else if (sched_phase == PH_FAST0 && r.clear_request) begin
            res.action = ACT_CLEAR_CODES;
        end else if (sched_phase == PH_FAST0 && r.scan_request) begin
            res.action = ACT_SCAN_CODES;
        end else if (sched_phase == PH_FAST0 && r.odometer_request) begin
            res.action = ACT_READ_ODO;
        end else begin
            // Channel 0 restarts its timer on every visit, so it never times out.
            if (sched_phase == PH_FAST0) begin
                sched_chan = 4'd0;
                slot_ms    = r.now_ms;
            end
            ch    = (sched_chan < NCH) ? sched_chan : 4'd0;
            go_on = skip_ch[ch];
            if (!go_on) begin
                if (r.outcome == OUTC_OK) begin
                    fail_cnt[ch] = 8'd0;
                    seen_ok[ch]  = 1'b1;
                    err_run      = 8'd0;
                    act          = ACT_STORE;
                    go_on        = 1'b1;
                end else if (r.outcome != OUTC_PENDING || (r.now_ms - slot_ms) > lim_stuck) begin
                    if (fail_cnt[ch] < COUNT_MAX)
                        fail_cnt[ch]++;
                    if (fail_cnt[ch] >= lim_fail) begin
                        if (seen_ok[ch]) begin
                            recon = 1'b1;
                        end else begin
                            skip_ch[ch] = 1'b1;
                            act         = ACT_CLEAR_FIELD;
                        end
                    end
                    // A channel that has worked before and reaches the fail limit forces a
                    // reconnect without touching the error run.
                    if (!recon) begin
                        if (err_run < COUNT_MAX)
                            err_run++;
                        recon = (err_run >= lim_err);
                    end
                    go_on = !recon;
                end
            end
            if (go_on) begin
                if (sched_phase == PH_FAST0) begin
                    sched_phase = PH_FAST1;
                    sched_chan  = 4'd1;
                    slot_ms     = r.now_ms;
                end else if (sched_phase == PH_FAST1) begin
                    found = 1'b0;
                    for (int i = 0; i < NCH - FIRST_SLOW; i++) begin
                        if (!found) begin
                            slow_ptr = (slow_ptr + 1 >= NCH) ? 4'(FIRST_SLOW) : slow_ptr + 4'd1;
                            found    = !skip_ch[slow_ptr];
                        end
                    end
                    // With every slow channel skipped the cycle runs on the fast ones only.
                    if (found) begin
                        sched_phase = PH_SLOW;
                        sched_chan  = slow_ptr;
                        slot_ms     = r.now_ms;
                    end else begin
                        sched_phase = PH_FAST0;
                    end
                end else begin
                    sched_phase = PH_FAST0;
                end
            end
            res.action         = recon ? ACT_RECONNECT : act;
            res.action_channel = ch;
        end
        res.next_channel = (sched_phase == PH_FAST0) ? 4'd0 : sched_chan;
        case (res.action)
            ACT_STORE:       n_stores++;
            ACT_CLEAR_FIELD: n_skips++;
            ACT_RECONNECT:   n_reconnects++;
            ACT_CLEAR_CODES, ACT_SCAN_CODES, ACT_READ_ODO: n_service++;
            default: ;
        endcase
        sched_expect_q.push_back(res);
    endtask

    function automatic t_poll_req mk_req(input logic [1:0] op, input logic [1:0] oc,
                                         input logic [31:0] now, input logic link,
                                         input logic clr, input logic scan, input logic odo);
        t_poll_req r;
        r.operation        = op;
        r.outcome          = oc;
        r.now_ms           = now;
        r.link_up          = link;
        r.clear_request    = clr;
        r.scan_request     = scan;
        r.odometer_request = odo;
        return r;
    endfunction

    // Mostly plain polls on a clock that moves about the stuck limit, with the
    // occasional restart, resume, dropped link, service request or jump in time.
    function automatic t_poll_req rand_req();
        t_poll_req   r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            r.operation = OP_RESTART;
        else if (pick < 6)
            r.operation = OP_RESUME_SCAN;
        else if (pick < 10)
            r.operation = OP_RESUME_ODO;
        else
            r.operation = OP_POLL;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.outcome = OUTC_OK;
        else if (pick < 68)
            r.outcome = OUTC_ERROR;
        else if (pick < 93)
            r.outcome = OUTC_PENDING;
        else
            r.outcome = OUTC_ODD;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            clock_ms = $urandom();
        else if (pick == 1)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * lim_stuck + 2);
        else if (pick < 5)
            clock_ms = clock_ms + 32'(lim_stuck) + $urandom_range(0, 1);
        else
            clock_ms = clock_ms + $urandom_range(0, lim_stuck + lim_stuck / 2 + 2);
        r.now_ms           = clock_ms;
        r.link_up          = ($urandom_range(0, 19) != 0);
        r.clear_request    = ($urandom_range(0, 24) == 0);
        r.scan_request     = ($urandom_range(0, 24) == 0);
        r.odometer_request = ($urandom_range(0, 24) == 0);
        return r;
    endfunction

    task automatic queue_req(input t_poll_req r);
        pend_q.push_back(r);
        reqs_issued++;
    endtask

    task automatic queue_random(input int unsigned count);
        repeat (count) queue_req(rand_req());
    endtask

    task automatic wait_results();
        while (results_checked != reqs_issued) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FAIL_LIMIT:  lim_fail  = data[7:0];
            CFG_ERROR_LIMIT: lim_err   = data[7:0];
            CFG_STUCK_LIMIT: lim_stuck = data;
            default: ;
        endcase
    endtask

    // The upper byte of the 8-bit limits carries random bits that must be dropped.
    task automatic set_limits(input logic [7:0] fail_lim, input logic [7:0] err_lim,
                              input logic [15:0] stuck_lim);
        write_reg(CFG_FAIL_LIMIT, {8'($urandom()), fail_lim});
        write_reg(CFG_ERROR_LIMIT, {8'($urandom()), err_lim});
        write_reg(CFG_STUCK_LIMIT, stuck_lim);
        n_settings++;
    endtask

    // Request side: bursts of requests with idle gaps between them. A request
    // stays on the port until it has been taken.
    always @(posedge i_clk) begin : req_driver
        logic took;
        if (i_rst_n) begin
            took = i_in_valid && !o_in_stall;
            if (took)
                predict_schedule(drv_req);
            if (!i_in_valid || took) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    drv_req    <= pend_q.pop_front();
                    i_in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(30, 60);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(1, 12);
                        end
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: spans of no stall, random stall and solid stall.
    always @(posedge i_clk) begin : stall_pattern
        if (stall_span == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_span = (stall_mode == STALL_NONE) ? $urandom_range(10, 60) : $urandom_range(1, 16);
        end
        stall_span--;
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_RANDOM: i_out_stall <= 1'($urandom_range(0, 1));
            default:      i_out_stall <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_sched_res want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (sched_expect_q.size() == 0) begin
                $error("result with nothing expected: action %0d channel %0d next %0d",
                       o_action, o_action_channel, o_next_channel);
                fail_count++;
            end else begin
                want = sched_expect_q.pop_front();
                if (o_action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_action);
                    fail_count++;
                end
                if (o_action_channel !== want.action_channel) begin
                    $error("action_channel: expected %0d, got %0d",
                           want.action_channel, o_action_channel);
                    fail_count++;
                end
                if (o_next_channel !== want.next_channel) begin
                    $error("next_channel: expected %0d, got %0d", want.next_channel, o_next_channel);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin : quiet_count
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("no handshake for %0d cycles, run abandoned", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned errs;
        clear_schedule();
        clock_ms = $urandom();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset limits: the link check and service requests in priority order,
        // the stuck timer on both sides of its limit, time wrapping, and the
        // operations that restart or resume the schedule.
        queue_req(mk_req(OP_POLL, OUTC_OK, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_OK, 32'd10, 1'b1, 1'b1, 1'b1, 1'b1));
        queue_req(mk_req(OP_POLL, OUTC_OK, 32'd10, 1'b1, 1'b0, 1'b1, 1'b1));
        queue_req(mk_req(OP_POLL, OUTC_OK, 32'd10, 1'b1, 1'b0, 1'b0, 1'b1));
        queue_req(mk_req(OP_RESUME_SCAN, OUTC_OK, 32'd20, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_OK, 32'd100, 1'b1, 1'b0, 1'b0, 1'b0));
        // Off the first fast slot the link and the requests are not looked at.
        queue_req(mk_req(OP_POLL, OUTC_OK, 32'd200, 1'b0, 1'b1, 1'b1, 1'b1));
        queue_req(mk_req(OP_POLL, OUTC_PENDING, 32'd1700, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_PENDING, 32'd1701, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_ODD, 32'd1800, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_PENDING, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_OK, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_PENDING, 32'd5000, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_PENDING, 32'd90000, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_RESUME_ODO, OUTC_ERROR, 32'd90001, 1'b0, 1'b1, 1'b1, 1'b1));
        queue_req(mk_req(OP_RESTART, OUTC_ODD, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        wait_results();

        // Lowest fail and stuck limits: every slow channel gets skipped one by
        // one, then the schedule runs on the fast channels alone, and a failure
        // on a channel that worked before forces a reconnect.
        set_limits(8'd1, 8'd255, 16'd0);
        write_reg(CFG_UNUSED, 16'($urandom()));
        for (int k = 0; k < NCH - FIRST_SLOW; k++) begin
            clock_ms = clock_ms + $urandom_range(1, 5);
            queue_req(mk_req(OP_POLL, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
            clock_ms = clock_ms + $urandom_range(1, 5);
            queue_req(mk_req(OP_POLL, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
            clock_ms = clock_ms + $urandom_range(1, 5);
            queue_req(mk_req(OP_POLL,
                             (k % 3 == 0) ? OUTC_PENDING :
                             ((k % 3 == 1) ? OUTC_ERROR : OUTC_ODD),
                             clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        end
        repeat (4) queue_req(mk_req(OP_POLL, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (2) queue_req(mk_req(OP_POLL, OUTC_ERROR, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_RESUME_ODO, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_random(30);
        wait_results();

        set_limits(8'd3, 8'd5, 16'd200);
        queue_random(45);
        wait_results();

        // Saturation: with an error limit of one the schedule sticks on channel 0,
        // so each error there raises both its failure count and the error run
        // until both stop at their ceiling.
        set_limits(8'd255, 8'd1, 16'd65535);
        queue_req(mk_req(OP_RESTART, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_POLL, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        repeat (2) queue_req(mk_req(OP_POLL, OUTC_ERROR, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(OP_RESUME_SCAN, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        errs = 0;
        while (errs < 262) begin
            clock_ms = clock_ms + $urandom_range(0, 70000);
            if ($urandom_range(0, 9) == 0) begin
                queue_req(mk_req(OP_POLL, OUTC_ERROR, clock_ms, 1'b0, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end else begin
                queue_req(mk_req(OP_POLL, $urandom_range(0, 1) ? OUTC_ERROR : OUTC_ODD,
                                 clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
                errs++;
            end
        end
        queue_req(mk_req(OP_POLL, OUTC_OK, clock_ms, 1'b1, 1'b0, 1'b0, 1'b0));
        wait_results();

        set_limits(8'($urandom_range(2, 6)), 8'($urandom_range(3, 12)), 16'($urandom_range(0, 3000)));
        queue_random(30);
        wait_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sched_expect_q.size() != 0) begin
            $error("%0d results never arrived", sched_expect_q.size());
            fail_count++;
        end
        $display("Checked %0d scheduler results under %0d sets of limits.",
                 results_checked, n_settings);
        $display("Stores %0d, channel skips %0d, reconnects %0d, service actions %0d.",
                 n_stores, n_skips, n_reconnects, n_service);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
